/* sv/mouse_motion_quadrature_generator_top_defines.svh */
// Assertion macros for the mouse motion quadrature generator checker.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef MOUSE_MOTION_QUADRATURE_GENERATOR_TOP_DEFINES_SVH
`define MOUSE_MOTION_QUADRATURE_GENERATOR_TOP_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define MMQG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent checked in the same cycle as the antecedent
`define MMQG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/mmqg_pkg.sv */
// Shared widths, request and register codes, reset values and types.
// No dependencies.
`default_nettype none

package mmqg_pkg;

    localparam int SUM_W      = 16;
    localparam int PER_W      = 21;
    localparam int Q_W        = 20;
    localparam int RATE_W     = 16;
    localparam int PAT_W      = 32;
    localparam int CYC_W      = 32;
    localparam int BASE_W     = 12;
    localparam int STEP_W     = 8;
    localparam int MAX_W      = 16;
    localparam int NUM_W      = 20;
    localparam int PROD_W     = 24;
    localparam int REQ_W      = 3;
    localparam int BTN_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    localparam logic [REQ_W-1:0] REQ_MOVE_X = 3'd0;
    localparam logic [REQ_W-1:0] REQ_MOVE_Y = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LEFT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RIGHT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_INIT = 3'd4;

    localparam logic [BASE_W-1:0] FREQ_BASE_RST = 12'd75;
    localparam logic [STEP_W-1:0] FREQ_STEP_RST = 8'd20;
    localparam logic [MAX_W-1:0]  FREQ_MAX_RST  = 16'd1500;
    localparam logic [NUM_W-1:0]  NUMERATOR_RST = 20'd1000000;
    localparam logic [PAT_W-1:0]  PATTERN_RST   = 32'h3333_3333;

    typedef struct packed {
        logic move;
        logic sample;
        logic tick;
        logic pat_load;
    } axis_ctrl_t;

endpackage

`default_nettype wire

/* sv/mmqg_if.sv */
// Request and result channel interfaces (valid/ready plus payload).
// Depends on mmqg_pkg.
`default_nettype none

interface mmqg_req_if;
    logic                                valid;
    logic                                ready;
    logic [mmqg_pkg::REQ_W-1:0]          req_type;
    logic signed [mmqg_pkg::SUM_W-1:0]   delta;
    logic                                pressed;
    logic [mmqg_pkg::CYC_W-1:0]          cycle_count;

    modport source (output valid, output req_type, output delta, output pressed,
                    output cycle_count, input ready);
    modport sink   (input valid, input req_type, input delta, input pressed,
                    input cycle_count, output ready);
endinterface

interface mmqg_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [mmqg_pkg::PAT_W-1:0]          x_pattern;
    logic [mmqg_pkg::PAT_W-1:0]          y_pattern;
    logic [mmqg_pkg::BTN_W-1:0]          buttons;
    logic signed [mmqg_pkg::PER_W-1:0]   x_period;
    logic signed [mmqg_pkg::PER_W-1:0]   y_period;

    modport source (output valid, output x_pattern, output y_pattern, output buttons,
                    output x_period, output y_period, input ready);
    modport sink   (input valid, input x_pattern, input y_pattern, input buttons,
                    input x_period, input y_period, output ready);
endinterface

`default_nettype wire

/* sv/mmqg_div.sv */
// Restoring divider, one quotient bit per cycle through a shift register.
// Depends on mmqg_pkg.
`default_nettype none

module mmqg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mmqg_pkg::NUM_W-1:0]  dividend,
    input  logic [mmqg_pkg::RATE_W-1:0] divisor,
    output logic                        done,
    output logic [mmqg_pkg::NUM_W-1:0]  quotient
);
    import mmqg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RATE_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [RATE_W-1:0]    dvs_reg, dvs_next;
    logic [RATE_W:0]      shifted;
    logic [RATE_W:0]      trial;
    logic                 take;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign take    = !trial[RATE_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = take ? trial[RATE_W-1:0] : shifted[RATE_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/mmqg_axis.sv */
// One axis: motion sum, period, due cycle and rotating pattern.
// Depends on mmqg_pkg.
`default_nettype none

module mmqg_axis (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mmqg_pkg::axis_ctrl_t               ctrl,
    input  logic signed [mmqg_pkg::SUM_W-1:0]  delta,
    input  logic [mmqg_pkg::CYC_W-1:0]         now,
    input  logic [mmqg_pkg::Q_W-1:0]           quotient,
    input  logic [mmqg_pkg::PAT_W-1:0]         pattern_init,
    output logic signed [mmqg_pkg::SUM_W-1:0]  sum,
    output logic signed [mmqg_pkg::PER_W-1:0]  per,
    output logic [mmqg_pkg::PAT_W-1:0]         pat
);
    import mmqg_pkg::*;

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [PER_W-1:0] per_reg, per_next;
    logic [CYC_W-1:0] due_reg, due_next;
    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [SUM_W:0]   sum_add;
    logic [PER_W-1:0] per_mag;
    logic [PER_W-1:0] q_ext;
    logic             fire;

    assign sum_add = {delta[SUM_W-1], delta} + {sum_reg[SUM_W-1], sum_reg};
    assign per_mag = per_reg[PER_W-1] ? (~per_reg + 1'b1) : per_reg;
    assign q_ext   = {1'b0, quotient};
    assign fire    = (per_reg != '0) && (now >= due_reg);

    always_comb
    begin
        sum_next = sum_reg;
        per_next = per_reg;
        due_next = due_reg;
        pat_next = pat_reg;
        if (ctrl.move)
        begin
            if (sum_add[SUM_W] != sum_add[SUM_W-1])
                sum_next = sum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
            else
                sum_next = sum_add[SUM_W-1:0];
        end
        if (ctrl.sample)
        begin
            sum_next = '0;
            if (sum_reg == '0)
            begin
                per_next = '0;
                due_next = '0;
            end
            else
            begin
                per_next = sum_reg[SUM_W-1] ? (~q_ext + 1'b1) : q_ext;
                due_next = now + {{(CYC_W-Q_W){1'b0}}, quotient};
            end
        end
        if (ctrl.tick && fire)
        begin
            // positive period rotates right, negative rotates left
            pat_next = per_reg[PER_W-1] ? {pat_reg[PAT_W-2:0], pat_reg[PAT_W-1]}
                                        : {pat_reg[0], pat_reg[PAT_W-1:1]};
            due_next = due_reg + {{(CYC_W-PER_W){1'b0}}, per_mag};
        end
        if (ctrl.pat_load)
            pat_next = pattern_init;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            per_reg <= '0;
            due_reg <= '0;
            pat_reg <= PATTERN_RST;
        end
        else
        begin
            sum_reg <= sum_next;
            per_reg <= per_next;
            due_reg <= due_next;
            pat_reg <= pat_next;
        end
    end

    assign sum = sum_reg;
    assign per = per_reg;
    assign pat = pat_reg;

endmodule

`default_nettype wire

/* sv/mouse_motion_quadrature_generator_top.sv */
// Mouse motion quadrature generator: one result word per request word, showing
// patterns, buttons and periods after the request. Move, button, tick and
// unused requests go from idle straight to the finish state. A sample computes
// each axis rate in the rate state and then runs the shared restoring divider,
// one quotient bit per cycle over 20 bits, for the x axis and then the y axis,
// and loads the result in the finish state once the output is free, then
// returns to idle. A new request is taken while the previous result still
// waits on the output. No clearing pass after reset.
// Depends on mmqg_pkg, mmqg_if, mmqg_div and mmqg_axis.
`default_nettype none

module mouse_motion_quadrature_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mmqg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mmqg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    mmqg_req_if.sink                            req,
    mmqg_rsp_if.source                          rsp
);
    import mmqg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RATE   = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic              sel_reg, sel_next;
    logic [CYC_W-1:0]  now_reg, now_next;
    logic [BTN_W-1:0]  btn_reg, btn_next;
    logic              out_valid_reg, out_valid_next;
    logic [BASE_W-1:0] base_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MAX_W-1:0]  max_reg;
    logic [NUM_W-1:0]  num_reg;

    logic [PAT_W-1:0]  out_xpat_reg, out_ypat_reg;
    logic [BTN_W-1:0]  out_btn_reg;
    logic [PER_W-1:0]  out_xper_reg, out_yper_reg;

    logic              accept;
    logic              load_out;
    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    quotient;
    axis_ctrl_t        x_ctrl, y_ctrl;
    logic [CYC_W-1:0]  axis_now;
    logic signed [SUM_W-1:0] x_sum, y_sum;
    logic signed [PER_W-1:0] x_per, y_per;
    logic [PAT_W-1:0]  x_pat, y_pat;

    logic [SUM_W-1:0]  sel_sum;
    logic [SUM_W:0]    mag;
    logic [SUM_W:0]    mag_m1;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rate_raw;
    logic [RATE_W-1:0] rate_clamp;
    logic [RATE_W-1:0] divisor;
    logic              pat_load;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);
    assign div_start = (state_reg == S_RATE);
    assign pat_load  = cfg_we && (cfg_index == CFG_PATTERN_INIT);

    // rate = min((|sum| - 1) * step + base, max), zero taken as one
    assign sel_sum    = sel_reg ? y_sum : x_sum;
    assign mag        = sel_sum[SUM_W-1] ? (~{sel_sum[SUM_W-1], sel_sum} + 1'b1)
                                         : {1'b0, sel_sum};
    assign mag_m1     = mag - 1'b1;
    assign prod       = {{(PROD_W-SUM_W){1'b0}}, mag_m1[SUM_W-1:0]}
                      * {{(PROD_W-STEP_W){1'b0}}, step_reg};
    assign rate_raw   = prod + {{(PROD_W-BASE_W){1'b0}}, base_reg};
    assign rate_clamp = (rate_raw > {{(PROD_W-MAX_W){1'b0}}, max_reg})
                      ? max_reg : rate_raw[RATE_W-1:0];
    assign divisor    = (rate_clamp == '0) ? {{(RATE_W-1){1'b0}}, 1'b1} : rate_clamp;

    assign axis_now = (state_reg == S_IDLE) ? req.cycle_count : now_reg;

    always_comb
    begin
        x_ctrl.move     = accept && (req.req_type == REQ_MOVE_X);
        x_ctrl.tick     = accept && (req.req_type == REQ_TICK);
        x_ctrl.sample   = (state_reg == S_DIV) && div_done && !sel_reg;
        x_ctrl.pat_load = pat_load;
        y_ctrl.move     = accept && (req.req_type == REQ_MOVE_Y);
        y_ctrl.tick     = accept && (req.req_type == REQ_TICK);
        y_ctrl.sample   = (state_reg == S_DIV) && div_done && sel_reg;
        y_ctrl.pat_load = pat_load;
    end

    mmqg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    mmqg_axis u_axis_x (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (x_ctrl),
        .delta        (req.delta),
        .now          (axis_now),
        .quotient     (quotient),
        .pattern_init (cfg_wdata[PAT_W-1:0]),
        .sum          (x_sum),
        .per          (x_per),
        .pat          (x_pat)
    );

    mmqg_axis u_axis_y (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (y_ctrl),
        .delta        (req.delta),
        .now          (axis_now),
        .quotient     (quotient),
        .pattern_init (cfg_wdata[PAT_W-1:0]),
        .sum          (y_sum),
        .per          (y_per),
        .pat          (y_pat)
    );

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        now_next       = now_reg;
        btn_next       = btn_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next = req.cycle_count;
                    sel_next = 1'b0;
                    if (req.req_type == REQ_LEFT)
                        btn_next[1] = req.pressed;
                    if (req.req_type == REQ_RIGHT)
                        btn_next[0] = req.pressed;
                    state_next = (req.req_type == REQ_SAMPLE) ? S_RATE : S_FINISH;
                end
            end
            S_RATE:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        state_next = S_RATE;
                    end
                    else
                        state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            btn_reg       <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= FREQ_BASE_RST;
            step_reg      <= FREQ_STEP_RST;
            max_reg       <= FREQ_MAX_RST;
            num_reg       <= NUMERATOR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            btn_reg       <= btn_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FREQ_BASE:    base_reg <= cfg_wdata[BASE_W-1:0];
                    CFG_FREQ_STEP:    step_reg <= cfg_wdata[STEP_W-1:0];
                    CFG_FREQ_MAX:     max_reg  <= cfg_wdata[MAX_W-1:0];
                    CFG_NUMERATOR:    num_reg  <= cfg_wdata[NUM_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        if (load_out)
        begin
            out_xpat_reg <= x_pat;
            out_ypat_reg <= y_pat;
            out_btn_reg  <= btn_reg;
            out_xper_reg <= x_per;
            out_yper_reg <= y_per;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.x_pattern = out_xpat_reg;
    assign rsp.y_pattern = out_ypat_reg;
    assign rsp.buttons   = out_btn_reg;
    assign rsp.x_period  = out_xper_reg;
    assign rsp.y_period  = out_yper_reg;

endmodule

`default_nettype wire

/* sv/mmqg_checker.sv */
// Port-level checker for the quadrature generator, bound to the top level.
// Depends on mmqg_pkg and the assertion macro header.
`default_nettype none

`include "mouse_motion_quadrature_generator_top_defines.svh"

module mmqg_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [mmqg_pkg::BTN_W-1:0]  out_buttons,
    input  logic [mmqg_pkg::PER_W-1:0]  out_x_period
);
    import mmqg_pkg::*;

    logic [2:0] pending_reg, pending_next;
    logic       in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    `MMQG_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "result word dropped")
    `MMQG_ASSERT_NEXT(a_word_hold, out_valid && !out_ready, $stable(out_buttons) && $stable(out_x_period), "stalled word changed")
    `MMQG_ASSERT_SAME(a_no_extra, out_acc, pending_reg != 3'd0, "result word without request word")
    `MMQG_ASSERT_SAME(a_depth, in_valid || !in_valid, pending_reg <= 3'd2, "too many words in flight")

endmodule

bind mouse_motion_quadrature_generator_top mmqg_checker u_mmqg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_buttons  (rsp.buttons),
    .out_x_period (rsp.x_period)
);

`default_nettype wire
